// ===== rtl/core/length_xor_frame_receiver_defines.svh =====
// assertion macros for the length/xor frame receiver
// used by the rtl files that carry concurrent assertions; no other dependencies
`ifndef LENGTH_XOR_FRAME_RECEIVER_DEFINES_SVH
`define LENGTH_XOR_FRAME_RECEIVER_DEFINES_SVH
`ifndef SYNTHESIS
// combinational property, checked outside reset
`define LXFR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lxfr assertion failed");
// condition now implies result in the next cycle, checked outside reset
`define LXFR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lxfr assertion failed");
// condition now implies result in the next cycle, checked through reset
`define LXFR_ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("lxfr assertion failed");
`else
`define LXFR_ASSERT(label, clk, rst, prop)
`define LXFR_ASSERT_NEXT(label, clk, rst, pre, post)
`define LXFR_ASSERT_NEXT_ALWAYS(label, clk, pre, post)
`endif
`endif

// ===== rtl/core/lxfr_pkg.sv =====
// shared constants and types for the length/xor frame receiver
// no dependencies
package lxfr_pkg;

   // receive buffer size in bytes, 4 .. 255
   localparam int RX_BUFFER_BYTES = 32;
   localparam int COUNT_W = $clog2(RX_BUFFER_BYTES + 1);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(RX_BUFFER_BYTES);

   localparam logic [7:0] XOR_SEED = 8'hFF;

   // frame positions
   localparam logic [COUNT_W-1:0] POS_LENGTH  = COUNT_W'(0);
   localparam logic [COUNT_W-1:0] POS_COMMAND = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] POS_ARG_LO  = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] POS_ARG_HI  = COUNT_W'(5);

   // known command range
   localparam logic [7:0] CMD_FIRST_KNOWN = 8'd1;
   localparam logic [7:0] CMD_LAST_KNOWN  = 8'd4;

   // result status codes
   localparam logic [1:0] STATUS_KNOWN     = 2'd0;
   localparam logic [1:0] STATUS_CSUM_ERR  = 2'd1;
   localparam logic [1:0] STATUS_OTHER_CMD = 2'd2;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         command_code;
      logic signed [15:0] arg_first;
      logic signed [15:0] arg_second;
   } lxfr_result_type;

endpackage

// ===== rtl/core/length_xor_frame_receiver.sv =====
// length-prefixed frame receiver with xor checksum, top level
// depends on lxfr_pkg, lxfr_parser and length_xor_frame_receiver_defines.svh
//
// usage:
//   req channel: one received byte per transaction on req_rx_byte, taken at a
//   clock edge where req_valid is high and req_stall is low.
//   rsp channel: one transaction per completed frame with rsp_status,
//   rsp_command_code, rsp_arg_first and rsp_arg_second; bytes that do not
//   complete a frame give no transaction.
//   result: the result of a frame's last byte is registered and shown on the
//   rsp side in the cycle after that byte is taken.
//   throughput: one byte per cycle when not stalled; the frame state is one
//   register update per byte and the result passes through one output register.
//   stall: while a result is held with rsp_stall high, req_stall is raised
//   so that the output register is not overwritten; it drops in the cycle the
//   result is taken, so a new byte can enter in that same cycle.
//   reset: clears the byte count, the running xor to 0xFF, the captured bytes
//   and the output valid.
`include "length_xor_frame_receiver_defines.svh"

module length_xor_frame_receiver
   import lxfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_command_code,
   output logic signed [15:0] rsp_arg_first,
   output logic signed [15:0] rsp_arg_second
);

   logic            byte_accept;
   logic            frame_done;
   lxfr_result_type frame_result;
   logic            rsp_valid_ff, rsp_valid_in;
   lxfr_result_type rsp_data_ff;

   // input may enter unless a held result is still waiting
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign byte_accept = req_valid && !req_stall;

   lxfr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .rx_byte      (req_rx_byte),
      .frame_done   (frame_done),
      .frame_result (frame_result)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (byte_accept && frame_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_accept && frame_done) begin
         rsp_data_ff <= frame_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_command_code = rsp_data_ff.command_code;
   assign rsp_arg_first    = rsp_data_ff.arg_first;
   assign rsp_arg_second   = rsp_data_ff.arg_second;

   // checks
   `LXFR_ASSERT(a_err_payload_zero, clock, reset, !(rsp_valid_ff && rsp_status == STATUS_CSUM_ERR) || (rsp_command_code == 8'd0 && rsp_arg_first == 16'sd0 && rsp_arg_second == 16'sd0))
   `LXFR_ASSERT(a_known_cmd_range, clock, reset, !(rsp_valid_ff && rsp_status == STATUS_KNOWN) || (rsp_command_code >= CMD_FIRST_KNOWN && rsp_command_code <= CMD_LAST_KNOWN))
   `LXFR_ASSERT(a_status_legal, clock, reset, !rsp_valid_ff || rsp_status != 2'd3)
   `LXFR_ASSERT_NEXT(a_done_shows_result, clock, reset, byte_accept && frame_done, rsp_valid_ff && rsp_data_ff == $past(frame_result))
   `LXFR_ASSERT_NEXT_ALWAYS(a_reset_clears_valid, clock, reset, !rsp_valid_ff)

endmodule

// ===== rtl/core/lxfr_parser.sv =====
// frame state tracking: byte count, running xor, command and argument capture
// depends on lxfr_pkg
module lxfr_parser
   import lxfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            byte_accept,
   input  logic [7:0]      rx_byte,
   output logic            frame_done,
   output lxfr_result_type frame_result
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         length_ff, length_in;
   logic [7:0]         xor_ff, xor_in;
   logic [7:0]         command_ff, command_in;
   logic [7:0]         args_ff [4];
   logic [7:0]         args_in [4];

   logic [COUNT_W-1:0] pos;
   logic [COUNT_W-1:0] taken;
   logic [COUNT_W-1:0] arg_offset;
   logic [7:0]         prior_xor;
   logic               frame_start;
   logic               bad;

   // position of this byte, with restart on buffer full
   always_comb begin
      pos         = (count_ff >= COUNT_LIMIT) ? POS_LENGTH : count_ff;
      frame_start = (pos == POS_LENGTH);
      taken       = pos + COUNT_W'(1);
      arg_offset  = pos - POS_ARG_LO;
      prior_xor   = frame_start ? XOR_SEED : xor_ff;
   end

   // capture of length, command and argument bytes
   always_comb begin
      length_in  = length_ff;
      command_in = command_ff;
      args_in    = args_ff;
      if (frame_start) begin
         length_in  = rx_byte;
         command_in = '0;
         for (int i = 0; i < 4; i++) begin
            args_in[i] = '0;
         end
      end else if (pos == POS_COMMAND) begin
         command_in = rx_byte;
      end else if (pos <= POS_ARG_HI) begin
         args_in[arg_offset[1:0]] = rx_byte;
      end
   end

   // completion check and result build
   always_comb begin
      frame_done = (length_in == 8'd0) || (8'(taken) >= length_in);
      bad        = (length_in == 8'd0) || (prior_xor != rx_byte);
      if (bad) begin
         frame_result.status       = STATUS_CSUM_ERR;
         frame_result.command_code = '0;
         frame_result.arg_first    = '0;
         frame_result.arg_second   = '0;
      end else begin
         frame_result.status = (command_in >= CMD_FIRST_KNOWN &&
                                command_in <= CMD_LAST_KNOWN) ? STATUS_KNOWN
                                                              : STATUS_OTHER_CMD;
         frame_result.command_code = command_in;
         frame_result.arg_first    = {args_in[0], args_in[1]};
         frame_result.arg_second   = {args_in[2], args_in[3]};
      end
      count_in = frame_done ? POS_LENGTH : taken;
      xor_in   = frame_done ? XOR_SEED : (prior_xor ^ rx_byte);
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         length_ff  <= '0;
         xor_ff     <= XOR_SEED;
         command_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            args_ff[i] <= '0;
         end
      end else if (byte_accept) begin
         count_ff   <= count_in;
         length_ff  <= length_in;
         xor_ff     <= xor_in;
         command_ff <= command_in;
         args_ff    <= args_in;
      end
   end

endmodule
